// File: hdl/sldf_pkg.sv
// ============================================================================
// sldf_pkg - shared constants of the sync/length frame deframer
// Sync pattern, length limits, parse phase codes and result kinds.
// ============================================================================
package sldf_pkg;

    // sync pair
    localparam logic [7:0] SYNC_FIRST  = 8'hD5;
    localparam logic [7:0] SYNC_SECOND = 8'hC8;

    // body length limits
    localparam logic [15:0] MIN_BODY_LEN   = 16'd6;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd256;

    // parse phase codes
    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_SYNC1  = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_LEN_HI = 3'd3;
    localparam logic [2:0] PH_BODY   = 3'd4;

    // result kinds
    localparam logic KIND_BODY    = 1'b0;
    localparam logic KIND_LEN_ERR = 1'b1;

endpackage

// File: hdl/sync_length_frame_deframer.sv
// A byte taken into the input register is parsed, and its result word is registered onto the outputs.
// Throughput: one byte per cycle unless stalled; one parse step between input and result register.
// Backpressure on the result side holds the input register and stalls the input.
// Reset: hunting for the first sync byte, length and count zero, max length 256.
// Reset is asynchronous, active low, and clears all control state.
// ============================================================================
// sync_length_frame_deframer - sync word, length prefixed frame deframer
// Hunts for 0xD5 0xC8, reads a little-endian 16-bit body length, rejects
// lengths below 6 or above the configured maximum, then streams the body
// bytes with their index and a last-of-frame mark.
// ============================================================================
module sync_length_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // input word
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // result word
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  body_byte,
    output logic [15:0] byte_index,
    output logic        frame_last,
    output logic        result_kind
);

    // registers
    logic [15:0] max_len_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic [2:0]  phase_reg,  phase_next;
    logic [15:0] len_reg,    len_next;
    logic [15:0] rem_reg,    rem_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [15:0] out_index_reg;
    logic        out_last_reg;
    logic        out_kind_reg;

    // step results
    logic        advance;
    logic        res_valid;
    logic [7:0]  res_byte;
    logic [15:0] res_index;
    logic        res_last;
    logic        res_kind;
    logic [15:0] len_cand;

    // pipeline control: move when the result register is free or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= sldf_pkg::MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    assign len_cand = {in_byte_reg, len_reg[7:0]};

    // parse step
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        res_valid  = 1'b0;
        res_byte   = 8'd0;
        res_index  = 16'd0;
        res_last   = 1'b0;
        res_kind   = sldf_pkg::KIND_BODY;
        if (advance && in_valid_reg)
        begin
            case (phase_reg)
                sldf_pkg::PH_SYNC1:
                begin
                    if (in_byte_reg == sldf_pkg::SYNC_SECOND)
                    begin
                        phase_next = sldf_pkg::PH_LEN_LO;
                    end
                    else if (in_byte_reg == sldf_pkg::SYNC_FIRST)
                    begin
                        phase_next = sldf_pkg::PH_SYNC1;
                    end
                    else
                    begin
                        phase_next = sldf_pkg::PH_HUNT;
                    end
                end
                sldf_pkg::PH_LEN_LO:
                begin
                    len_next   = {8'd0, in_byte_reg};
                    phase_next = sldf_pkg::PH_LEN_HI;
                end
                sldf_pkg::PH_LEN_HI:
                begin
                    len_next = len_cand;
                    if (len_cand < sldf_pkg::MIN_BODY_LEN || len_cand > max_len_reg)
                    begin
                        phase_next = sldf_pkg::PH_HUNT;
                        res_valid  = 1'b1;
                        res_kind   = sldf_pkg::KIND_LEN_ERR;
                    end
                    else
                    begin
                        rem_next   = len_cand;
                        phase_next = sldf_pkg::PH_BODY;
                    end
                end
                sldf_pkg::PH_BODY:
                begin
                    rem_next  = rem_reg - 16'd1;
                    res_valid = 1'b1;
                    res_byte  = in_byte_reg;
                    res_index = len_reg - rem_reg;
                    if (rem_reg == 16'd1)
                    begin
                        res_last   = 1'b1;
                        phase_next = sldf_pkg::PH_HUNT;
                    end
                end
                default:
                begin
                    // hunting, unused codes included
                    phase_next = (in_byte_reg == sldf_pkg::SYNC_FIRST) ?
                                 sldf_pkg::PH_SYNC1 : sldf_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sldf_pkg::PH_HUNT;
            len_reg   <= 16'd0;
            rem_reg   <= 16'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_byte_reg  <= res_byte;
            out_index_reg <= res_index;
            out_last_reg  <= res_last;
            out_kind_reg  <= res_kind;
        end
    end

    assign out_valid   = out_valid_reg;
    assign body_byte   = out_byte_reg;
    assign byte_index  = out_index_reg;
    assign frame_last  = out_last_reg;
    assign result_kind = out_kind_reg;

`ifndef SYNTHESIS
    // error words carry an all-zero payload
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == sldf_pkg::KIND_LEN_ERR |->
        body_byte == 8'd0 && byte_index == 16'd0 && !frame_last)
        else $error("length error word with nonzero payload");

    // a body in progress always has bytes left
    a_body_rem: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == sldf_pkg::PH_BODY |-> rem_reg != 16'd0)
        else $error("body phase with zero remaining count");

    // last body byte returns the parser to hunting
    a_last_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_valid_reg && phase_reg == sldf_pkg::PH_BODY && rem_reg == 16'd1
        |=> phase_reg == sldf_pkg::PH_HUNT && out_valid && frame_last)
        else $error("frame end not followed by hunt");

    // input only stalls while a result word is held
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without held result");
`endif

endmodule

// File: tb/tb_sync_length_frame_deframer.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_sync_length_frame_deframer - self-checking bench for the frame deframer
// Feeds byte streams of sync pairs, length fields and bodies under random
// idle and stall, predicts every result word from a behavioral deframer and
// compares each field in order. Covers several max-length settings.
// ============================================================================
module tb_sync_length_frame_deframer;

    localparam int STALL_LIMIT  = 3000;  // cycles with no word moving
    localparam int DRAIN_CYCLES = 4;     // result passes the input and the result register
    localparam int RANDOM_BYTES = 800;

    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] pos;
        logic        last;
        logic        kind;
    } frame_word_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [15:0] cfg_wdata   = 16'd0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte     = 8'd0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [7:0]  body_byte;
    logic [15:0] byte_index;
    logic        frame_last;
    logic        result_kind;

    wire in_fire  = in_valid && !in_stall;
    wire out_fire = out_valid && !out_stall;

    // deframer shadow state
    logic [2:0]  rx_phase;
    logic [15:0] rx_len;
    logic [15:0] rx_left;
    logic [15:0] max_len;

    frame_word_t pending_words[$];
    bit          steady = 1'b0;      // no idling on either side
    logic [15:0] cur_max = sldf_pkg::MAX_LEN_RESET;
    int          mismatches = 0;
    int          frames_done = 0;
    int          len_errors = 0;
    int          words_checked = 0;
    int          max_writes = 0;
    int          idle_cycles = 0;

    sync_length_frame_deframer u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .body_byte   (body_byte),
        .byte_index  (byte_index),
        .frame_last  (frame_last),
        .result_kind (result_kind)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one parse step; returns 1 when the byte yields a result word
    function automatic bit deframe_step(input logic [7:0] b, output frame_word_t w);
        logic [15:0] len;
        w = '0;
        deframe_step = 1'b0;
        case (rx_phase)
            sldf_pkg::PH_SYNC1:
            begin
                if (b == sldf_pkg::SYNC_SECOND)
                    rx_phase = sldf_pkg::PH_LEN_LO;
                else if (b == sldf_pkg::SYNC_FIRST)
                    rx_phase = sldf_pkg::PH_SYNC1;
                else
                    rx_phase = sldf_pkg::PH_HUNT;
            end
            sldf_pkg::PH_LEN_LO:
            begin
                rx_len   = {8'h00, b};
                rx_phase = sldf_pkg::PH_LEN_HI;
            end
            sldf_pkg::PH_LEN_HI:
            begin
                len    = {b, rx_len[7:0]};
                rx_len = len;
                if (len < sldf_pkg::MIN_BODY_LEN || len > max_len)
                begin
                    rx_phase     = sldf_pkg::PH_HUNT;
                    w.kind       = sldf_pkg::KIND_LEN_ERR;
                    deframe_step = 1'b1;
                end
                else
                begin
                    rx_left  = len;
                    rx_phase = sldf_pkg::PH_BODY;
                end
            end
            sldf_pkg::PH_BODY:
            begin
                w.data  = b;
                w.pos   = rx_len - rx_left;
                rx_left = rx_left - 16'd1;
                w.last  = (rx_left == 16'd0);
                w.kind  = sldf_pkg::KIND_BODY;
                if (w.last)
                    rx_phase = sldf_pkg::PH_HUNT;
                deframe_step = 1'b1;
            end
            // unused codes behave as hunting
            default: rx_phase = (b == sldf_pkg::SYNC_FIRST) ? sldf_pkg::PH_SYNC1
                                                              : sldf_pkg::PH_HUNT;
        endcase
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // prediction on accepted bytes, checking on accepted result words
    always @(posedge clk)
    begin
        frame_word_t w;
        if (!rst_n)
        begin
            rx_phase = sldf_pkg::PH_HUNT;
            rx_len   = 16'd0;
            rx_left  = 16'd0;
            max_len  = sldf_pkg::MAX_LEN_RESET;
        end
        else
        begin
            if (cfg_we)
                max_len = cfg_wdata;
            if (in_fire && deframe_step(rx_byte, w))
                pending_words.push_back(w);
            if (out_fire)
            begin
                if (pending_words.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none, got data %0d index %0d",
                             $time, body_byte, byte_index);
                    $display("%0t: unexpected word, last %0d kind %0d",
                             $time, frame_last, result_kind);
                end
                else
                begin
                    w = pending_words.pop_front();
                    words_checked++;
                    check_field("body_byte", 32'(w.data), 32'(body_byte));
                    check_field("byte_index", 32'(w.pos), 32'(byte_index));
                    check_field("frame_last", 32'(w.last), 32'(frame_last));
                    check_field("result_kind", 32'(w.kind), 32'(result_kind));
                    if (w.kind == sldf_pkg::KIND_LEN_ERR)
                        len_errors++;
                    else if (w.last)
                        frames_done++;
                end
            end
        end
    end

    // receiver stall
    always @(negedge clk)
        out_stall <= !steady && ($urandom_range(99) < 13);

    // watchdog on cycles where no word moves
    always @(posedge clk)
    begin
        if (in_fire || out_fire || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // all tasks below start and end at a falling edge
    task automatic send_byte(input logic [7:0] b);
        // idle at random, each idle step drawn with a chance of 13 in a hundred
        while (!steady && $urandom_range(99) < 13)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // quiet input, wait for every expected word and the pipeline to settle
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_max_len(input logic [15:0] value);
        wait_idle();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        cur_max   = value;
        max_writes++;
    endtask

    // header then, for an accepted length, a body of random bytes
    task automatic send_frame(input logic [15:0] len, input int extra_sync);
        logic [7:0] b;
        send_byte(sldf_pkg::SYNC_FIRST);
        repeat (extra_sync) send_byte(sldf_pkg::SYNC_FIRST);
        send_byte(sldf_pkg::SYNC_SECOND);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        if (len >= sldf_pkg::MIN_BODY_LEN && len <= cur_max)
        begin
            for (int i = 0; i < int'(len); i++)
            begin
                case ($urandom_range(19))
                    0:       b = sldf_pkg::SYNC_FIRST;
                    1:       b = sldf_pkg::SYNC_SECOND;
                    default: b = 8'($urandom_range(255));
                endcase
                send_byte(b);
            end
        end
    endtask

    task automatic test_sync_and_limits();
        // noise, repeated first sync byte, shortest body holding sync bytes
        send_byte(8'h00);
        send_byte(sldf_pkg::SYNC_FIRST);
        send_byte(sldf_pkg::SYNC_FIRST);
        send_byte(sldf_pkg::SYNC_SECOND);
        send_byte(8'h06);
        send_byte(8'h00);
        send_byte(sldf_pkg::SYNC_FIRST);
        send_byte(sldf_pkg::SYNC_SECOND);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(sldf_pkg::SYNC_FIRST);
        send_byte(sldf_pkg::SYNC_SECOND);
        // broken sync, then a length one short of the minimum
        send_byte(sldf_pkg::SYNC_FIRST);
        send_byte(8'h12);
        send_frame(16'd5, 0);
        // one above the reset maximum, the largest length and zero
        send_frame(sldf_pkg::MAX_LEN_RESET + 16'd1, 0);
        send_frame(16'hFFFF, 0);
        send_frame(16'd0, 0);
    endtask

    task automatic test_max_extremes();
        write_max_len(16'd6);
        send_frame(16'd6, 0);
        send_frame(16'd7, 0);
        // maximum below the minimum rejects everything
        write_max_len(16'd0);
        send_frame(16'd6, 0);
        send_frame(16'd0, 0);
        write_max_len(16'd5);
        send_frame(16'd5, 0);
    endtask

    // largest maximum settings: one short of the top rejects the top length
    task automatic test_top_max_len();
        write_max_len(16'hFFFE);
        send_frame(16'hFFFF, 0);
        write_max_len(16'hFFFF);
        send_frame(16'd100, 1);
    endtask

    task automatic test_drain_pauses();
        write_max_len(16'd32);
        for (int i = 0; i < 5; i++)
        begin
            send_frame(16'($urandom_range(6, 32)), $urandom_range(0, 1));
            wait_idle();
        end
    endtask

    task automatic test_random_frames();
        int sent;
        int phase_end;
        int sel;
        int hi;
        logic [15:0] len;
        sent = 0;
        for (int p = 0; sent < RANDOM_BYTES; p++)
        begin
            case (p % 4)
                0:       write_max_len(16'($urandom_range(6, 64)));
                1:       write_max_len(sldf_pkg::MAX_LEN_RESET);
                2:       write_max_len(16'($urandom_range(65, 300)));
                default: write_max_len(16'd6);
            endcase
            steady    = (p == 2);
            phase_end = sent + 200;
            while (sent < phase_end)
            begin
                sel = $urandom_range(99);
                if (sel < 8)
                begin
                    // line noise while hunting
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
                end
                else if (sel < 14)
                begin
                    // sync pair broken by a wrong second byte
                    send_byte(sldf_pkg::SYNC_FIRST);
                    send_byte($urandom_range(0, 1) ? 8'h00 : 8'hC9);
                end
                else
                begin
                    sel = $urandom_range(99);
                    hi  = (cur_max > 16'd48) ? 48 : int'(cur_max);
                    if (sel < 70)
                        len = ($urandom_range(9) == 0) ? 16'($urandom_range(6, cur_max))
                                                       : 16'($urandom_range(6, hi));
                    else if (sel < 85)
                        len = 16'($urandom_range(0, 5));
                    else if (sel < 92)
                        len = cur_max + 16'd1;
                    else
                        len = 16'($urandom_range(cur_max + 1, 65535));
                    send_frame(len, ($urandom_range(7) == 0) ? $urandom_range(1, 2) : 0);
                    sent += 4;
                    if (len >= sldf_pkg::MIN_BODY_LEN && len <= cur_max)
                        sent += int'(len);
                end
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_sync_and_limits();
        test_max_extremes();
        test_drain_pauses();
        test_top_max_len();
        test_random_frames();

        wait_idle();
        repeat (10) @(posedge clk);
        $display("Checked %0d result words: %0d complete frames, %0d rejected lengths,",
                 words_checked, frames_done, len_errors);
        $display("over %0d max-length settings including 0, 6, 256 and 65535.", max_writes);
        if (pending_words.size() != 0)
            $display("%0t: missing words, expected %0d more, got 0",
                     $time, pending_words.size());
        if (mismatches == 0 && pending_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
